/* rtl/core/egrad_pkg.sv */
package egrad_pkg;

  localparam int QBITS   = 48;
  localparam int LNUM_W  = 63;
  localparam int LDIV_W  = 32 + QBITS - 1;
  localparam int RNUM_W  = 94;
  localparam int RDIV_W  = 63 + QBITS - 1;
  localparam int BETA_W  = 48;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_MAX = 3'd4;
  localparam logic [2:0] MODE_MIN = 3'd5;

  localparam logic [1:0] REG_OP_MODE     = 2'd0;
  localparam logic [1:0] REG_GRAD_SCALE  = 2'd1;
  localparam logic [1:0] REG_ACCUM_SCALE = 2'd2;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [LNUM_W-1:0]        lrem;
    logic [LDIV_W-1:0]        ldiv;
    logic [QBITS-1:0]         lq;
    logic [RNUM_W-1:0]        rrem;
    logic [RDIV_W-1:0]        rdiv;
    logic [QBITS-1:0]         rq;
    logic                     lneg;
    logic                     rneg;
    logic                     lbig;
    logic                     rbig;
    logic                     use_q;
    logic signed [BETA_W-1:0] lbeta;
    logic signed [BETA_W-1:0] rbeta;
    logic [31:0]              lres;
    logic [31:0]              rres;
    logic                     flag;
    logic                     last;
  } div_word_t;

  typedef struct packed {
    logic [31:0] val;
    logic        hit;
  } sat_t;

  function automatic sat_t sat32(input logic signed [95:0] v);
    sat_t r;
    r.hit = 1'b1;
    r.val = Q_MAX;
    if (v > $signed({64'b0, Q_MAX})) begin
      r.val = Q_MAX;
    end else if (v < $signed({{64{1'b1}}, Q_MIN})) begin
      r.val = Q_MIN;
    end else begin
      r.hit = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/egrad_front.sv */
module egrad_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [31:0]     g,
  input  logic signed [31:0]     x,
  input  logic signed [31:0]     y,
  input  logic signed [31:0]     pl,
  input  logic signed [31:0]     pr,
  input  logic                   last,
  input  logic [2:0]             op_mode,
  input  logic signed [31:0]     grad_scale,
  input  logic signed [31:0]     accum_scale,
  output logic                   out_vld,
  output egrad_pkg::div_word_t   out_d
);

  // stage 1: scale products
  logic               s1_vld_r;
  logic signed [63:0] s1_ag_r, s1_bl_r, s1_br_r;
  logic [62:0]        s1_yy_r;
  logic signed [31:0] s1_x_r, s1_y_r;
  logic [2:0]         s1_mode_r;
  logic               s1_last_r, s1_ge_r, s1_le_r;
  logic signed [63:0] ag_nxt, bl_nxt, br_nxt, yy_nxt;

  assign ag_nxt = grad_scale * g;
  assign bl_nxt = accum_scale * pl;
  assign br_nxt = accum_scale * pr;
  assign yy_nxt = y * y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
    if (en) begin
      s1_ag_r   <= ag_nxt;
      s1_bl_r   <= bl_nxt;
      s1_br_r   <= br_nxt;
      s1_yy_r   <= yy_nxt[62:0];
      s1_x_r    <= x;
      s1_y_r    <= y;
      s1_mode_r <= op_mode;
      s1_last_r <= last;
      s1_ge_r   <= (x >= y);
      s1_le_r   <= (x <= y);
    end
  end

  // stage 2: partial products of |ag| with |x| and |y|
  logic               s2_vld_r;
  logic signed [63:0] s2_ag_r, s2_bl_r, s2_br_r;
  logic [62:0]        s2_yy_r, s2_agm_r;
  logic [31:0]        s2_ym_r;
  logic [2:0]         s2_mode_r;
  logic               s2_last_r, s2_ge_r, s2_le_r, s2_agneg_r, s2_xneg_r, s2_yneg_r;
  logic               s2_yzero_r;
  logic [63:0]        s2_pyl_r, s2_pxl_r;
  logic [62:0]        s2_pyh_r, s2_pxh_r;
  logic [63:0]        agabs;
  logic [31:0]        xm_nxt, ym_nxt;
  logic [63:0]        pyl_nxt, pxl_nxt;
  logic [62:0]        pyh_nxt, pxh_nxt;

  always_comb begin
    agabs   = s1_ag_r[63] ? (64'd0 - s1_ag_r) : s1_ag_r;
    xm_nxt  = s1_x_r[31] ? (32'd0 - s1_x_r) : s1_x_r;
    ym_nxt  = s1_y_r[31] ? (32'd0 - s1_y_r) : s1_y_r;
    pyl_nxt = agabs[31:0] * ym_nxt;
    pxl_nxt = agabs[31:0] * xm_nxt;
    pyh_nxt = agabs[62:32] * ym_nxt;
    pxh_nxt = agabs[62:32] * xm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_ag_r    <= s1_ag_r;
      s2_bl_r    <= s1_bl_r;
      s2_br_r    <= s1_br_r;
      s2_yy_r    <= s1_yy_r;
      s2_agm_r   <= agabs[62:0];
      s2_ym_r    <= ym_nxt;
      s2_mode_r  <= s1_mode_r;
      s2_last_r  <= s1_last_r;
      s2_ge_r    <= s1_ge_r;
      s2_le_r    <= s1_le_r;
      s2_agneg_r <= s1_ag_r[63];
      s2_xneg_r  <= s1_x_r[31];
      s2_yneg_r  <= s1_y_r[31];
      s2_yzero_r <= (s1_y_r == 32'sd0);
      s2_pyl_r   <= pyl_nxt;
      s2_pxl_r   <= pxl_nxt;
      s2_pyh_r   <= pyh_nxt;
      s2_pxh_r   <= pxh_nxt;
    end
  end

  // stage 3: combine partial products, apply sign
  logic               s3_vld_r;
  logic signed [63:0] s3_ag_r, s3_bl_r, s3_br_r;
  logic [62:0]        s3_yy_r, s3_agm_r;
  logic [31:0]        s3_ym_r;
  logic [2:0]         s3_mode_r;
  logic               s3_last_r, s3_ge_r, s3_le_r, s3_agneg_r, s3_yneg_r, s3_yzero_r;
  logic [egrad_pkg::RNUM_W-1:0] s3_mx_r;
  logic signed [95:0] s3_py_r, s3_px_r;
  logic [95:0]        my96, mx96, py_nxt, px_nxt;

  always_comb begin
    my96   = {s2_pyh_r[62:0], 33'b0} >> 1;
    my96   = my96 + {32'b0, s2_pyl_r};
    mx96   = {s2_pxh_r[62:0], 33'b0} >> 1;
    mx96   = mx96 + {32'b0, s2_pxl_r};
    py_nxt = (s2_agneg_r ^ s2_yneg_r) ? (96'd0 - my96) : my96;
    px_nxt = (s2_agneg_r ^ s2_xneg_r) ? (96'd0 - mx96) : mx96;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
    if (en) begin
      s3_ag_r    <= s2_ag_r;
      s3_bl_r    <= s2_bl_r;
      s3_br_r    <= s2_br_r;
      s3_yy_r    <= s2_yy_r;
      s3_agm_r   <= s2_agm_r;
      s3_ym_r    <= s2_ym_r;
      s3_mode_r  <= s2_mode_r;
      s3_last_r  <= s2_last_r;
      s3_ge_r    <= s2_ge_r;
      s3_le_r    <= s2_le_r;
      s3_agneg_r <= s2_agneg_r;
      s3_yneg_r  <= s2_yneg_r;
      s3_yzero_r <= s2_yzero_r;
      s3_mx_r    <= mx96[egrad_pkg::RNUM_W-1:0];
      s3_py_r    <= py_nxt;
      s3_px_r    <= px_nxt;
    end
  end

  // stage 4: direct results, divider setup
  logic signed [63:0]   tl, tr;
  logic [64:0]          sl, sr;
  logic [95:0]          ml, mr;
  egrad_pkg::sat_t      sat_l, sat_r;
  egrad_pkg::div_word_t d_nxt;
  logic                 px_pos;

  always_comb begin
    tl = 64'sd0;
    tr = 64'sd0;
    case (s3_mode_r)
      egrad_pkg::MODE_ADD: begin
        tl = s3_ag_r;
        tr = s3_ag_r;
      end
      egrad_pkg::MODE_SUB: begin
        tl = s3_ag_r;
        tr = -s3_ag_r;
      end
      egrad_pkg::MODE_MAX: begin
        tl = s3_ge_r ? s3_ag_r : 64'sd0;
        tr = s3_le_r ? s3_ag_r : 64'sd0;
      end
      egrad_pkg::MODE_MIN: begin
        tl = s3_le_r ? s3_ag_r : 64'sd0;
        tr = s3_ge_r ? s3_ag_r : 64'sd0;
      end
      default: begin
        tl = 64'sd0;
        tr = 64'sd0;
      end
    endcase
    sl = {tl[63], tl} + {s3_bl_r[63], s3_bl_r};
    sr = {tr[63], tr} + {s3_br_r[63], s3_br_r};
    ml = s3_py_r + {{16{s3_bl_r[63]}}, s3_bl_r, 16'b0};
    mr = s3_px_r + {{16{s3_br_r[63]}}, s3_br_r, 16'b0};
    if (s3_mode_r == egrad_pkg::MODE_MUL) begin
      sat_l = egrad_pkg::sat32($signed({{32{ml[95]}}, ml[95:32]}));
      sat_r = egrad_pkg::sat32($signed({{32{mr[95]}}, mr[95:32]}));
    end else begin
      sat_l = egrad_pkg::sat32($signed({{47{sl[64]}}, sl[64:16]}));
      sat_r = egrad_pkg::sat32($signed({{47{sr[64]}}, sr[64:16]}));
    end
    px_pos = !s3_px_r[95] && (s3_px_r != 96'sd0);

    d_nxt       = '0;
    d_nxt.lbeta = s3_bl_r[63:16];
    d_nxt.rbeta = s3_br_r[63:16];
    d_nxt.last  = s3_last_r;
    d_nxt.lres  = sat_l.val;
    d_nxt.rres  = sat_r.val;
    d_nxt.flag  = sat_l.hit | sat_r.hit;
    if (s3_mode_r == egrad_pkg::MODE_DIV) begin
      if (s3_yzero_r) begin
        d_nxt.lres = s3_agneg_r ? egrad_pkg::Q_MIN : egrad_pkg::Q_MAX;
        d_nxt.rres = px_pos ? egrad_pkg::Q_MIN : egrad_pkg::Q_MAX;
        d_nxt.flag = 1'b1;
      end else begin
        d_nxt.use_q = 1'b1;
        d_nxt.flag  = 1'b0;
        d_nxt.lrem  = s3_agm_r;
        d_nxt.ldiv  = {s3_ym_r, {(egrad_pkg::QBITS-1){1'b0}}};
        d_nxt.lbig  = {17'b0, s3_agm_r} >= {s3_ym_r, {egrad_pkg::QBITS{1'b0}}};
        d_nxt.lneg  = s3_agneg_r ^ s3_yneg_r;
        d_nxt.rrem  = s3_mx_r;
        d_nxt.rdiv  = {s3_yy_r, {(egrad_pkg::QBITS-1){1'b0}}};
        d_nxt.rbig  = {17'b0, s3_mx_r} >= {s3_yy_r, {egrad_pkg::QBITS{1'b0}}};
        d_nxt.rneg  = px_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= s3_vld_r;
    end
    if (en) begin
      out_d <= d_nxt;
    end
  end

endmodule

/* rtl/core/egrad_cell.sv */
module egrad_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  egrad_pkg::div_word_t in_d,
  output logic                 out_vld,
  output egrad_pkg::div_word_t out_d
);

  egrad_pkg::div_word_t d_nxt;
  logic                 ltake, rtake;
  logic [egrad_pkg::LDIV_W-1:0] lext;
  logic [egrad_pkg::RDIV_W-1:0] rext;

  // one quotient bit per lane: compare, subtract, shift divisor down
  always_comb begin
    lext  = {{(egrad_pkg::LDIV_W-egrad_pkg::LNUM_W){1'b0}}, in_d.lrem};
    rext  = {{(egrad_pkg::RDIV_W-egrad_pkg::RNUM_W){1'b0}}, in_d.rrem};
    ltake = lext >= in_d.ldiv;
    rtake = rext >= in_d.rdiv;
    d_nxt      = in_d;
    d_nxt.ldiv = in_d.ldiv >> 1;
    d_nxt.rdiv = in_d.rdiv >> 1;
    d_nxt.lq   = {in_d.lq[egrad_pkg::QBITS-2:0], ltake};
    d_nxt.rq   = {in_d.rq[egrad_pkg::QBITS-2:0], rtake};
    if (ltake) begin
      d_nxt.lrem = egrad_pkg::LNUM_W'(lext - in_d.ldiv);
    end
    if (rtake) begin
      d_nxt.rrem = egrad_pkg::RNUM_W'(rext - in_d.rdiv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_d <= d_nxt;
    end
  end

endmodule

/* rtl/core/egrad_back.sv */
module egrad_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  egrad_pkg::div_word_t in_d,
  output logic                 out_vld_r,
  output logic [31:0]          out_left_r,
  output logic [31:0]          out_right_r,
  output logic                 out_sat_r,
  output logic                 out_last_r
);

  logic [49:0]     ql, qr, suml, sumr;
  egrad_pkg::sat_t sat_l, sat_r;
  logic [31:0]     left_nxt, right_nxt;
  logic            sat_nxt;

  always_comb begin
    ql   = in_d.lneg ? (50'd0 - {2'b0, in_d.lq}) : {2'b0, in_d.lq};
    qr   = in_d.rneg ? (50'd0 - {2'b0, in_d.rq}) : {2'b0, in_d.rq};
    suml = ql + {{2{in_d.lbeta[47]}}, in_d.lbeta};
    sumr = qr + {{2{in_d.rbeta[47]}}, in_d.rbeta};
    sat_l = egrad_pkg::sat32($signed({{46{suml[49]}}, suml}));
    sat_r = egrad_pkg::sat32($signed({{46{sumr[49]}}, sumr}));
    if (in_d.lbig) begin
      sat_l.val = in_d.lneg ? egrad_pkg::Q_MIN : egrad_pkg::Q_MAX;
      sat_l.hit = 1'b1;
    end
    if (in_d.rbig) begin
      sat_r.val = in_d.rneg ? egrad_pkg::Q_MIN : egrad_pkg::Q_MAX;
      sat_r.hit = 1'b1;
    end
    if (in_d.use_q) begin
      left_nxt  = sat_l.val;
      right_nxt = sat_r.val;
      sat_nxt   = sat_l.hit | sat_r.hit;
    end else begin
      left_nxt  = in_d.lres;
      right_nxt = in_d.rres;
      sat_nxt   = in_d.flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= in_vld;
    end
    if (en) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_sat_r   <= sat_nxt;
      out_last_r  <= in_d.last;
    end
  end

endmodule

/* rtl/core/elementwise_binary_gradient_top.sv */
// Backward gradient of an elementwise add, sub, mul, div, max or min on signed
// Q16.16 data: one word per clock in and out while the output is not stalled
// (multiplier and setup stages, a row of 48 divider cells that each settle one
// quotient bit of both divisions, one output register). A stall on the output
// freezes the whole pipeline. Write configuration only while no word is in flight.
module elementwise_binary_gradient_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // output_gradient, left_operand, right_operand, left_grad_prior, right_grad_prior
  input  logic [159:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_grad_new, right_grad_new
  output logic [63:0]  out_tdata,
  // saturated
  output logic         out_tuser,
  output logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  logic [2:0]         op_mode_r;
  logic signed [31:0] grad_scale_r, accum_scale_r;
  logic               en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r     <= egrad_pkg::MODE_ADD;
      grad_scale_r  <= 32'sd65536;
      accum_scale_r <= 32'sd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        egrad_pkg::REG_OP_MODE:     op_mode_r     <= cfg_wdata[2:0];
        egrad_pkg::REG_GRAD_SCALE:  grad_scale_r  <= cfg_wdata;
        egrad_pkg::REG_ACCUM_SCALE: accum_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic                 vld [0:egrad_pkg::QBITS];
  egrad_pkg::div_word_t dw  [0:egrad_pkg::QBITS];
  logic [egrad_pkg::QBITS:0] vld_vec;

  egrad_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (in_tvalid),
    .g           ($signed(in_tdata[31:0])),
    .x           ($signed(in_tdata[63:32])),
    .y           ($signed(in_tdata[95:64])),
    .pl          ($signed(in_tdata[127:96])),
    .pr          ($signed(in_tdata[159:128])),
    .last        (in_tlast),
    .op_mode     (op_mode_r),
    .grad_scale  (grad_scale_r),
    .accum_scale (accum_scale_r),
    .out_vld     (vld[0]),
    .out_d       (dw[0])
  );

  for (genvar i = 0; i < egrad_pkg::QBITS; i++) begin : g_cell
    egrad_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (vld[i]),
      .in_d    (dw[i]),
      .out_vld (vld[i+1]),
      .out_d   (dw[i+1])
    );
  end

  for (genvar j = 0; j <= egrad_pkg::QBITS; j++) begin : g_vld
    assign vld_vec[j] = vld[j];
  end

  egrad_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (vld[egrad_pkg::QBITS]),
    .in_d        (dw[egrad_pkg::QBITS]),
    .out_vld_r   (out_tvalid),
    .out_left_r  (out_tdata[31:0]),
    .out_right_r (out_tdata[63:32]),
    .out_sat_r   (out_tuser),
    .out_last_r  (out_tlast)
  );

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_vec))
    else $error("divider row moved during stall");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output register");

  a_drop_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) |-> $past(out_tready))
    else $error("result dropped without handshake");

endmodule

/* verif/egrad_checker.sv */
`timescale 1ns / 1ps

module egrad_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [159:0] in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           pending_grads
);

  typedef struct packed {
    logic [31:0] lgrad;
    logic [31:0] rgrad;
    logic        sat;
    logic        last;
  } grad_word_t;

  logic [2:0]         mode_q;
  logic signed [31:0] alpha_q;
  logic signed [31:0] beta_q;
  grad_word_t         grad_fifo[$];

  function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                    input logic signed [127:0] d);
    logic [127:0] nm, dm, q;
    logic         neg;
    begin
      neg = n[127] ^ d[127];
      nm  = n[127] ? -n : n;
      dm  = d[127] ? -d : d;
      q   = nm / dm;
      return neg ? -$signed(q) : $signed(q);
    end
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [127:0] v,
                                          inout logic hit);
    begin
      if (v > 128'sh7fffffff) begin
        hit = 1'b1;
        return egrad_pkg::Q_MAX;
      end else if (v < -128'sh80000000) begin
        hit = 1'b1;
        return egrad_pkg::Q_MIN;
      end
      return v[31:0];
    end
  endfunction

  function automatic grad_word_t predict_grads(input logic [159:0] d, input logic last);
    logic signed [127:0] g, x, y, pl, pr, ag, bl, br, lv, rv, rn;
    logic                hit;
    grad_word_t          w;
    begin
      g  = $signed(d[31:0]);
      x  = $signed(d[63:32]);
      y  = $signed(d[95:64]);
      pl = $signed(d[127:96]);
      pr = $signed(d[159:128]);
      ag = g * 128'($signed(alpha_q));
      bl = pl * 128'($signed(beta_q));
      br = pr * 128'($signed(beta_q));
      hit = 1'b0;
      case (mode_q)
        egrad_pkg::MODE_ADD: begin
          lv = (ag + bl) >>> 16;
          rv = (ag + br) >>> 16;
        end
        egrad_pkg::MODE_SUB: begin
          lv = (ag + bl) >>> 16;
          rv = (br - ag) >>> 16;
        end
        egrad_pkg::MODE_MUL: begin
          lv = (ag * y + (bl <<< 16)) >>> 32;
          rv = (ag * x + (br <<< 16)) >>> 32;
        end
        egrad_pkg::MODE_DIV: begin
          rn = -(ag * x);
          if (y == 0) begin
            hit = 1'b1;
            lv  = ag < 0 ? -128'sh80000000 : 128'sh7fffffff;
            rv  = rn < 0 ? -128'sh80000000 : 128'sh7fffffff;
          end else begin
            lv = trunc_div(ag, y) + (bl >>> 16);
            rv = trunc_div(rn, y * y) + (br >>> 16);
          end
        end
        egrad_pkg::MODE_MAX: begin
          lv = ((x >= y ? ag : 128'sd0) + bl) >>> 16;
          rv = ((y >= x ? ag : 128'sd0) + br) >>> 16;
        end
        egrad_pkg::MODE_MIN: begin
          lv = ((x <= y ? ag : 128'sd0) + bl) >>> 16;
          rv = ((y <= x ? ag : 128'sd0) + br) >>> 16;
        end
        default: begin
          lv = bl >>> 16;
          rv = br >>> 16;
        end
      endcase
      w.lgrad = clamp32(lv, hit);
      w.rgrad = clamp32(rv, hit);
      w.sat   = hit;
      w.last  = last;
      return w;
    end
  endfunction

  always @(posedge clk) begin
    grad_word_t e;
    if (!rst_n) begin
      mode_q     <= egrad_pkg::MODE_ADD;
      alpha_q    <= 32'sd65536;
      beta_q     <= 32'sd65536;
      fail_count <= 0;
      grad_fifo.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          egrad_pkg::REG_OP_MODE:     mode_q  <= cfg_wdata[2:0];
          egrad_pkg::REG_GRAD_SCALE:  alpha_q <= cfg_wdata;
          egrad_pkg::REG_ACCUM_SCALE: beta_q  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) grad_fifo.push_back(predict_grads(in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        if (grad_fifo.size() == 0) begin
          $display("%0t: unexpected word %h sat %b last %b", $time, out_tdata,
                   out_tuser, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          e = grad_fifo.pop_front();
          if (e.lgrad !== out_tdata[31:0] || e.rgrad !== out_tdata[63:32] ||
              e.sat !== out_tuser || e.last !== out_tlast) begin
            $display("%0t: expected l %h r %h sat %b last %b, got l %h r %h sat %b last %b",
                     $time, e.lgrad, e.rgrad, e.sat, e.last, out_tdata[31:0],
                     out_tdata[63:32], out_tuser, out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_grads <= grad_fifo.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REG_SPARE = 2'd3;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_wdata;
  int           fail_count;
  int           pending_grads;
  int           stall_mode;
  int           gap_left;
  logic         in_taken;

  elementwise_binary_gradient_top dut (.*);
  egrad_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
  end

  always @(negedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ~out_tready;
    endcase
  end

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h00010000;
      4: return 32'hffff0000;
      5: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_word(input logic [159:0] d, input logic last);
    int gap;
    if (gap_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      gap_left = $urandom_range(1, 30);
    end
    gap_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_grads != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic run_phase(input logic [2:0] mode, input logic [31:0] a,
                           input logic [31:0] b, input int n);
    logic [31:0] x;
    write_reg(egrad_pkg::REG_OP_MODE, {29'b0, mode});
    write_reg(egrad_pkg::REG_GRAD_SCALE, a);
    write_reg(egrad_pkg::REG_ACCUM_SCALE, b);
    stall_mode = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      x = pick_val();
      send_word({pick_val(), pick_val(), ($urandom_range(0, 3) == 0) ? x : pick_val(),
                 x, pick_val()}, 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b1;
    cfg_wr_en  = 1'b0;
    cfg_index  = egrad_pkg::REG_OP_MODE;
    cfg_wdata  = '0;
    stall_mode = 0;
    gap_left   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_word({32'h00020000, 32'h00010000, 32'h00030000, 32'h00030000, 32'h00010000}, 1'b0);
    send_word({32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff}, 1'b1);
    drain();
    for (int m = 0; m < 8; m++) begin
      run_phase(m[2:0], 32'h00010000, 32'h00010000, 3);
      run_phase(m[2:0], 32'h7fffffff, 32'h80000000, 2);
    end
    run_phase(egrad_pkg::MODE_DIV, 32'h00010000, 32'h0, 2);
    for (int p = 0; p < 24; p++)
      run_phase(3'($urandom_range(0, 7)), pick_val(), pick_val(), 50);
    write_reg(REG_SPARE, 32'hffffffff);
    run_phase(egrad_pkg::MODE_MUL, 32'h80000000, 32'h7fffffff, 20);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/egrad_pkg.sv
rtl/core/egrad_front.sv
rtl/core/egrad_cell.sv
rtl/core/egrad_back.sv
rtl/core/elementwise_binary_gradient_top.sv
verif/egrad_checker.sv
verif/tb.sv
